[rtl/div128_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div128_pkg
// Shared widths and stage types for the pipelined 128-by-64 divider.
// ----------------------------------------------------------------------------
package div128_pkg;

    localparam int WORD_W = 64;
    localparam int DIVIDEND_W = 2 * WORD_W;
    localparam int STEPS = DIVIDEND_W;

    // one partial remainder step travels with its operands and flags
    typedef struct packed {
        logic [WORD_W-1:0]     rem;
        logic [DIVIDEND_W-1:0] work;
        logic [WORD_W-1:0]     divisor;
        logic                  overflow;
        logic                  divide_by_zero;
    } stage_t;

    typedef struct packed {
        logic              divide_by_zero;
        logic              overflow;
        logic [WORD_W-1:0] remainder;
        logic [WORD_W-1:0] quotient;
    } result_t;

endpackage
`default_nettype wire

[rtl/divide_128_by_64_with_overflow.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// divide_128_by_64_with_overflow
// Unsigned 128-by-64 divider, one restoring step per pipeline stage.
//
// s_ channel takes {divisor, dividend_low, dividend_high}; m_ channel returns
// quotient and remainder in m_tdata, overflow and divide_by_zero in m_tuser.
// A transfer may enter every cycle while s_tready is high; throughput is one
// item per cycle while m_tready stays high. An input transfer loads the input
// register, then passes through 128 step stages (one per dividend bit) and
// the output register before it shows on m_tvalid.
// A zero divisor runs through the same steps and comes out with an all-ones
// quotient, the dividend low half as remainder, and both flags set.
// When m_tready is low the result waits in the output register and one more
// result lands in a skid slot; after that s_tready drops and every stage
// holds, so nothing is lost or repeated.
// Reset clears all valid bits; s_tready is high from the first cycle after
// reset.
// ----------------------------------------------------------------------------
module divide_128_by_64_with_overflow (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // dividend_high, dividend_low, divisor
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // quotient, remainder
    output logic [1:0]        m_tuser    // overflow, divide_by_zero
);
    import div128_pkg::*;

    logic              adv;
    logic              valid_pipe [0:STEPS];
    stage_t            stage_pipe [0:STEPS];
    logic              in_valid_reg;
    stage_t            in_stage_reg;
    stage_t            in_stage_next;
    logic [WORD_W-1:0] dividend_high;
    logic [WORD_W-1:0] dividend_low;
    logic [WORD_W-1:0] divisor;
    result_t           res;
    result_t           out_res;

    assign dividend_high = s_tdata[WORD_W-1:0];
    assign dividend_low  = s_tdata[2*WORD_W-1:WORD_W];
    assign divisor       = s_tdata[3*WORD_W-1:2*WORD_W];

    assign s_tready = adv;

    always_comb begin
        in_stage_next.rem            = '0;
        in_stage_next.work           = {dividend_high, dividend_low};
        in_stage_next.divisor        = divisor;
        in_stage_next.overflow       = (dividend_high >= divisor);
        in_stage_next.divide_by_zero = (divisor == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_stage_reg <= in_stage_next;
        end
    end

    assign valid_pipe[0] = in_valid_reg;
    assign stage_pipe[0] = in_stage_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        div128_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (valid_pipe[i]),
            .in_stage  (stage_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_stage (stage_pipe[i+1])
        );
    end

    always_comb begin
        res.quotient       = stage_pipe[STEPS].work[WORD_W-1:0];
        res.remainder      = stage_pipe[STEPS].rem;
        res.overflow       = stage_pipe[STEPS].overflow;
        res.divide_by_zero = stage_pipe[STEPS].divide_by_zero;
    end

    div128_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_pipe[STEPS]),
        .in_data   (res),
        .in_ready  (adv),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.remainder, out_res.quotient};
    assign m_tuser = {out_res.divide_by_zero, out_res.overflow};

endmodule
`default_nettype wire

[rtl/div128_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div128_step
// One registered restoring division step: shifts in the next dividend bit,
// trial-subtracts the divisor and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module div128_step (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire div128_pkg::stage_t in_stage,
    output logic                    out_valid,
    output div128_pkg::stage_t      out_stage
);
    import div128_pkg::*;

    logic                  valid_reg;
    stage_t                stage_reg;
    stage_t                stage_next;
    logic [WORD_W-1:0]     shifted;
    logic                  top;
    logic                  qbit;

    always_comb begin
        top      = in_stage.rem[WORD_W-1];
        shifted  = {in_stage.rem[WORD_W-2:0], in_stage.work[DIVIDEND_W-1]};
        qbit     = top || (shifted >= in_stage.divisor);
        stage_next         = in_stage;
        stage_next.rem     = qbit ? (shifted - in_stage.divisor) : shifted;
        stage_next.work    = {in_stage.work[DIVIDEND_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule
`default_nettype wire

[rtl/div128_skid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// div128_skid
// Output register with a skid slot; its ready is registered and stalls the
// whole pipeline only when both slots are full.
// ----------------------------------------------------------------------------
module div128_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire div128_pkg::result_t in_data,
    output logic                     in_ready,
    output logic                     out_valid,
    output div128_pkg::result_t      out_data,
    input  wire logic                out_ready
);
    import div128_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_take;

    assign in_ready = !skid_valid_reg;
    assign out_take = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[tb/divide_128_by_64_with_overflow_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divide_128_by_64_with_overflow_tb
// Self-checking bench for the pipelined unsigned 128-by-64 divider. Directed
// groups cover the operand extremes, the zero divisor and the overflow
// boundary. A random group follows with mostly in-range divides, plus
// overflowing, zero-divisor and unconstrained operands. Both stream sides idle
// at random, with stretches of full rate. Every result transfer is compared
// field by field against a prediction of the quotient, remainder and flags,
// from wide arithmetic or, for a zero divisor, from fixed values.
// ----------------------------------------------------------------------------
module divide_128_by_64_with_overflow_tb;

    import div128_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int MAX_IDLE       = 6;
    localparam int PIPE_LATENCY   = 130;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // dividend_high, dividend_low, divisor
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // quotient, remainder
    logic [1:0]   m_tuser;   // overflow, divide_by_zero

    result_t pending_divisions[$];
    result_t oldest_division;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      source_gaps_on = 1'b1;
    bit      sink_stalls_on = 1'b1;

    divide_128_by_64_with_overflow dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic result_t predict_division(input logic [WORD_W-1:0] high,
                                                 input logic [WORD_W-1:0] low,
                                                 input logic [WORD_W-1:0] div);
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVIDEND_W-1:0] wide_div;
        logic [DIVIDEND_W-1:0] wide_quot;
        logic [DIVIDEND_W-1:0] wide_rem;
        result_t r;
        dividend = {high, low};
        wide_div = {{WORD_W{1'b0}}, div};
        if (div == '0) begin
            r.quotient       = ALL_ONES;
            r.remainder      = low;
            r.overflow       = 1'b1;
            r.divide_by_zero = 1'b1;
        end else begin
            wide_quot        = dividend / wide_div;
            wide_rem         = dividend % wide_div;
            r.quotient       = wide_quot[WORD_W-1:0];
            r.remainder      = wide_rem[WORD_W-1:0];
            r.overflow       = (high >= div);
            r.divide_by_zero = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random magnitude, so small and large operands both show up
    function automatic logic [WORD_W-1:0] rand_scaled();
        return rand64() >> $urandom_range(0, WORD_W - 1);
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // input transfers feed the prediction queue, output transfers are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_divisions.push_back(predict_division(s_tdata[63:0], s_tdata[127:64],
                                                             s_tdata[191:128]));
            if (m_tvalid && m_tready) begin
                if (pending_divisions.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h %h",
                             $time, m_tuser, m_tdata);
                    mismatch_count++;
                end else begin
                    oldest_division = pending_divisions.pop_front();
                    if (m_tdata[63:0] !== oldest_division.quotient)
                        report_mismatch("quotient", oldest_division.quotient, m_tdata[63:0]);
                    if (m_tdata[127:64] !== oldest_division.remainder)
                        report_mismatch("remainder", oldest_division.remainder,
                                        m_tdata[127:64]);
                    if (m_tuser[0] !== oldest_division.overflow)
                        report_mismatch("overflow", 64'(oldest_division.overflow),
                                        64'(m_tuser[0]));
                    if (m_tuser[1] !== oldest_division.divide_by_zero)
                        report_mismatch("divide_by_zero", 64'(oldest_division.divide_by_zero),
                                        64'(m_tuser[1]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure, one draw per result
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_division(input logic [WORD_W-1:0] high, input logic [WORD_W-1:0] low,
                                 input logic [WORD_W-1:0] div);
        int gap;
        gap = source_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {div, low, high};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic test_operand_extremes;
        send_division('0, '0, 64'd1);
        send_division('0, '0, ALL_ONES);
        send_division('0, ALL_ONES, 64'd1);
        send_division('0, 64'd1, ALL_ONES);
        send_division(ALL_ONES - 64'd1, ALL_ONES, ALL_ONES);
        send_division('0, ALL_ONES, ALL_ONES);
        send_division('0, 64'd5, 64'd7);
        send_division(64'd3, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_zero_divisor;
        send_division('0, '0, '0);
        send_division(ALL_ONES, ALL_ONES, '0);
        send_division(rand64(), rand64(), '0);
        send_division('0, 64'h5555_aaaa_5555_aaaa, '0);
    endtask

    task automatic test_overflow_boundary;
        send_division(64'd1, '0, 64'd1);
        send_division(ALL_ONES, '0, 64'd1);
        send_division(ALL_ONES, ALL_ONES, ALL_ONES);
        send_division(64'd9, ALL_ONES, 64'd10);
        send_division(64'd10, ALL_ONES, 64'd10);
        // partial remainder gets its top bit set during the steps
        send_division(64'h8000_0000_0000_0000, ALL_ONES, 64'h8000_0000_0000_0001);
        send_division(ALL_ONES - 64'd1, '0, ALL_ONES);
        send_division(64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_random_divisions;
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] div;
        logic [WORD_W-1:0] swap;
        int kind;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            source_gaps_on = ((n / 50) % 3) != 2;
            sink_stalls_on = ((n / 50) % 4) != 3;
            kind = $urandom_range(0, 99);
            low  = rand64();
            div  = rand_scaled();
            if (div == '0)
                div = 64'd1;
            if (kind < 55) begin
                high = rand_scaled() % div;
            end else if (kind < 70) begin
                high = rand64();
                if (high < div) begin
                    swap = high;
                    high = div;
                    div  = (swap == '0) ? 64'd1 : swap;
                end
            end else if (kind < 78) begin
                high = div - 64'($urandom_range(0, 1));
            end else if (kind < 86) begin
                high = rand_scaled();
                div  = '0;
            end else begin
                high = rand64();
                div  = rand64();
            end
            send_division(high, low, div);
        end
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_operand_extremes();
        test_zero_divisor();
        test_overflow_boundary();
        test_random_divisions();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_divisions.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 20) @(posedge aclk);

        if (mismatch_count == 0 && pending_divisions.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
